// ----- src/mbe_pkg.sv -----
package mbe_pkg;

  // Fixed point format of all complex values
  localparam int FRAC_BITS = 28;
  localparam int VAL_W     = 32;
  localparam int STEP_W    = 31;
  localparam int PROD_W    = 2 * VAL_W;
  // Sum width before saturation; holds any product plus any value
  localparam int SUM_W     = PROD_W + 1;
  // Squares after the fraction shift, and the doubled cross term
  localparam int SQ_W      = PROD_W - FRAC_BITS;
  localparam int CROSS_W   = PROD_W - FRAC_BITS + 1;
  localparam int MAG_W     = SQ_W + 1;

  // Escape threshold 4.0 in Q4.28
  localparam logic signed [MAG_W-1:0] ESC_LIMIT = MAG_W'(64'd4 << FRAC_BITS);

  // Parameter defaults
  localparam int COORD_WIDTH_DEF = 12;
  localparam int ITER_WIDTH_DEF  = 17;

  // Register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;

  localparam logic signed [VAL_W-1:0] ORIGIN_RESET   = 32'shE000_0000;
  localparam logic [STEP_W-1:0]       STEP_RESET     = 31'd2684354;
  localparam int                      MAX_ITER_RESET = 100000;

  typedef struct packed {
    logic signed [VAL_W-1:0] real_origin;
    logic signed [VAL_W-1:0] imag_origin;
    logic [STEP_W-1:0]       real_step;
    logic [STEP_W-1:0]       imag_step;
  } cfg_t;

  // Clamp a wide signed sum to the 32-bit signed range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -SUM_W'(64'sh0000_0000_8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

endpackage

// ----- src/mandelbrot_escape_time.sv -----
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------------------
// in       | input     | in_valid_i / in_stall_o | pixel_x_i, pixel_y_i
// out      | output    | out_valid_o/ out_stall_i| out_x_o, out_y_o, iteration_count_o
// cfg      | input     | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// One 32x32 multiplier is shared by every product; each iteration of
// z = z*z + c uses it three times (S_MRR, S_MII, S_MRI) and then runs
// the escape test and the update of z in S_UPD. A finished pixel's word
// is loaded into the output register from S_UPD; the next pixel is taken
// once the block is back in S_IDLE. Reset restores the register defaults
// and empties the sequencer and the output register. A stalled output
// word holds in place; the block then waits in its final update cycle.
module mandelbrot_escape_time #(
  parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH_DEF,
  parameter int ITER_WIDTH  = mbe_pkg::ITER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [COORD_WIDTH-1:0]          pixel_x_i,
  input  logic [COORD_WIDTH-1:0]          pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [COORD_WIDTH-1:0]          out_x_o,
  output logic [COORD_WIDTH-1:0]          out_y_o,
  output logic [ITER_WIDTH-1:0]           iteration_count_o
);
  import mbe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MCR  = 3'd1;  // px * real_step
  localparam logic [2:0] S_MCI  = 3'd2;  // py * imag_step, finish c.re
  localparam logic [2:0] S_LDC  = 3'd3;  // finish c.im
  localparam logic [2:0] S_MRR  = 3'd4;  // zr * zr
  localparam logic [2:0] S_MII  = 3'd5;  // zi * zi, take rr
  localparam logic [2:0] S_MRI  = 3'd6;  // zr * zi, take ii
  localparam logic [2:0] S_UPD  = 3'd7;  // test escape, update z

  cfg_t                    cfg;
  logic [ITER_WIDTH-1:0]   max_iter;

  logic [2:0]              state_q, state_d;
  logic [COORD_WIDTH-1:0]  px_q, py_q;
  logic signed [VAL_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [SQ_W-1:0]  rr_q, ii_q;
  logic [ITER_WIDTH-1:0]   count_q;

  logic                    out_valid_q;
  logic [COORD_WIDTH-1:0]  out_x_q, out_y_q;
  logic [ITER_WIDTH-1:0]   out_cnt_q;

  logic signed [VAL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [CROSS_W-1:0] cross2;
  logic signed [MAG_W-1:0]   mag;
  logic signed [SUM_W-1:0]   coord_sum, nr_sum, ni_sum;
  logic                      done;
  logic                      out_free;
  logic                      in_take;

  mbe_regs #(
    .ITER_WIDTH (ITER_WIDTH)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .max_iter_o  (max_iter)
  );

  mbe_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Pick the operands of the shared multiplier
  always_comb begin
    mul_a = zr_q;
    mul_b = zi_q;
    case (state_q)
      S_MCR: begin
        mul_a = $signed(VAL_W'(px_q));
        mul_b = $signed({1'b0, cfg.real_step});
      end
      S_MCI: begin
        mul_a = $signed(VAL_W'(py_q));
        mul_b = $signed({1'b0, cfg.imag_step});
      end
      S_MRR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_MII: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  // Origin plus scaled index, and the update terms of one iteration
  always_comb begin
    if (state_q == S_MCI) begin
      coord_sum = SUM_W'(prod) + SUM_W'(cfg.real_origin);
    end else begin
      coord_sum = SUM_W'(prod) + SUM_W'(cfg.imag_origin);
    end
  end

  assign cross2 = $signed(prod[PROD_W-1:FRAC_BITS-1]);
  assign mag    = MAG_W'(rr_q) + MAG_W'(ii_q);
  assign nr_sum = SUM_W'(rr_q) - SUM_W'(ii_q) + SUM_W'(cr_q);
  assign ni_sum = SUM_W'(cross2) + SUM_W'(ci_q);
  assign done   = (count_q >= max_iter) || (mag >= ESC_LIMIT);

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_take  = in_valid_i && !in_stall_o;

  // Sequence the multiplier passes
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MCR;
      S_MCR:  state_d = S_MCI;
      S_MCI:  state_d = S_LDC;
      S_LDC:  state_d = S_MRR;
      S_MRR:  state_d = S_MII;
      S_MII:  state_d = S_MRI;
      S_MRI:  state_d = S_UPD;
      S_UPD: begin
        if (!done) begin
          state_d = S_MRR;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        px_q    <= pixel_x_i;
        py_q    <= pixel_y_i;
        zr_q    <= '0;
        zi_q    <= '0;
        count_q <= '0;
      end
      S_MCI: cr_q <= sat32(coord_sum);
      S_LDC: ci_q <= sat32(coord_sum);
      S_MII: rr_q <= $signed(prod[PROD_W-1:FRAC_BITS]);
      S_MRI: ii_q <= $signed(prod[PROD_W-1:FRAC_BITS]);
      S_UPD: begin
        if (!done) begin
          zr_q    <= sat32(nr_sum);
          zi_q    <= sat32(ni_sum);
          count_q <= count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_UPD && done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD && done && out_free) begin
      out_x_q   <= px_q;
      out_y_q   <= py_q;
      out_cnt_q <= count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_x_o           = out_x_q;
  assign out_y_o           = out_y_q;
  assign iteration_count_o = out_cnt_q;

  // Accepted word starts the coordinate pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == S_MCR)
    else $error("accepted word did not start the sequencer");

  // A fresh output word comes only from a finishing update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_UPD)
    else $error("output word loaded outside the update cycle");

  // A continuing iteration counts once and restarts the products
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !done) |=>
      (state_q == S_MRR && count_q == $past(count_q) + 1'b1))
    else $error("iteration did not advance");

  // A finished pixel waits while the output register is full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && done && out_valid_q && out_stall_i) |=> state_q == S_UPD)
    else $error("result overwrote a stalled output word");

endmodule

// ----- src/mbe_mul.sv -----
module mbe_mul (
  input  logic                               clk_i,
  input  logic signed [mbe_pkg::VAL_W-1:0]   a_i,
  input  logic signed [mbe_pkg::VAL_W-1:0]   b_i,
  output logic signed [mbe_pkg::PROD_W-1:0]  p_o
);
  import mbe_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // Register the full signed product every cycle
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- src/mbe_regs.sv -----
module mbe_regs #(
  parameter int ITER_WIDTH = mbe_pkg::ITER_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output mbe_pkg::cfg_t                     cfg_o,
  output logic [ITER_WIDTH-1:0]             max_iter_o
);
  import mbe_pkg::*;

  cfg_t                  cfg_q;
  logic [ITER_WIDTH-1:0] max_iter_q;

  // Write one register per enabled cycle; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_origin <= ORIGIN_RESET;
      cfg_q.imag_origin <= ORIGIN_RESET;
      cfg_q.real_step   <= STEP_RESET;
      cfg_q.imag_step   <= STEP_RESET;
      max_iter_q        <= ITER_WIDTH'(MAX_ITER_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REAL_ORIGIN: cfg_q.real_origin <= $signed(cfg_wdata_i[VAL_W-1:0]);
        REG_IMAG_ORIGIN: cfg_q.imag_origin <= $signed(cfg_wdata_i[VAL_W-1:0]);
        REG_REAL_STEP:   cfg_q.real_step   <= cfg_wdata_i[STEP_W-1:0];
        REG_IMAG_STEP:   cfg_q.imag_step   <= cfg_wdata_i[STEP_W-1:0];
        REG_MAX_ITER:    max_iter_q        <= cfg_wdata_i[ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o      = cfg_q;
  assign max_iter_o = max_iter_q;

endmodule

// ----- tb/sv/tb_mandelbrot_escape_time.sv -----
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;

  localparam int COORD_W = mbe_pkg::COORD_WIDTH_DEF;
  localparam int ITER_W = mbe_pkg::ITER_WIDTH_DEF;
  localparam int IDX_W = mbe_pkg::CFG_IDX_W;
  localparam int DATA_W = mbe_pkg::CFG_DATA_W;
  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint ESCAPE_Q = 64'sd1 << 30;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ITER_W-1:0]  count;
  } pixel_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [IDX_W-1:0]    cfg_index_i = '0;
  logic [DATA_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [COORD_W-1:0]  pixel_x_i = '0;
  logic [COORD_W-1:0]  pixel_y_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [COORD_W-1:0]  out_x_o;
  logic [COORD_W-1:0]  out_y_o;
  logic [ITER_W-1:0]   iteration_count_o;

  // Shadow copy of the register file, Q4.28 where it applies
  logic signed [31:0]  real_origin_q = -32'sd536870912;
  logic signed [31:0]  imag_origin_q = -32'sd536870912;
  logic [30:0]         real_step_q = 31'd2684354;
  logic [30:0]         imag_step_q = 31'd2684354;
  logic [ITER_W-1:0]   max_iter_q = ITER_W'(100000);

  pixel_result_t       pending_pixels[$];
  int                  sender_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  error_count = 0;
  int                  pixels_sent = 0;
  int                  words_checked = 0;
  int                  windows_programmed = 0;
  longint              cycle_count = 0;

  mandelbrot_escape_time dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .iteration_count_o (iteration_count_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Clamp to the signed 32-bit range
  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end else if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // Iterate z = z*z + c for one pixel under the current register settings
  function automatic int unsigned escape_count(input logic [COORD_W-1:0] px,
                                               input logic [COORD_W-1:0] py);
    longint cr;
    longint ci;
    longint zr;
    longint zi;
    longint zr_next;
    longint sq_r;
    longint sq_i;
    longint cross_term;
    longint mag;
    int unsigned n;
    cr = clamp_q(longint'(real_origin_q) + longint'(px) * longint'(real_step_q));
    ci = clamp_q(longint'(imag_origin_q) + longint'(py) * longint'(imag_step_q));
    zr = 0;
    zi = 0;
    mag = 0;
    n = 0;
    while (n < max_iter_q && mag < ESCAPE_Q) begin
      sq_r = (zr * zr) >>> 28;
      sq_i = (zi * zi) >>> 28;
      cross_term = (zr * zi) >>> 27;
      zr_next = clamp_q(sq_r - sq_i + cr);
      zi = clamp_q(cross_term + ci);
      zr = zr_next;
      mag = ((zr * zr) >>> 28) + ((zi * zi) >>> 28);
      n++;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Write one register and mirror it into the shadow copy
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      mbe_pkg::REG_REAL_ORIGIN: real_origin_q = data;
      mbe_pkg::REG_IMAG_ORIGIN: imag_origin_q = data;
      mbe_pkg::REG_REAL_STEP:   real_step_q = data[30:0];
      mbe_pkg::REG_IMAG_STEP:   imag_step_q = data[30:0];
      mbe_pkg::REG_MAX_ITER:    max_iter_q = data[ITER_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_window(input logic [31:0] r_origin, input logic [31:0] i_origin,
                                input logic [31:0] r_step, input logic [31:0] i_step,
                                input logic [31:0] limit);
    write_reg(mbe_pkg::REG_REAL_ORIGIN, r_origin);
    write_reg(mbe_pkg::REG_IMAG_ORIGIN, i_origin);
    write_reg(mbe_pkg::REG_REAL_STEP, r_step);
    write_reg(mbe_pkg::REG_IMAG_STEP, i_step);
    write_reg(mbe_pkg::REG_MAX_ITER, limit);
    windows_programmed++;
  endtask

  // Send one pixel word, with an optional gap ahead of it
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pixels.push_back('{x: px, y: py, count: ITER_W'(escape_count(px, py))});
    pixels_sent++;
  endtask

  // Drop valid, wait for every pending word, then let the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Corners of the default window, including saturated coordinates
  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 0);
    send_pixel(0, 12'd4095);
    send_pixel(12'd300, 12'd200);
    wait_idle();
  endtask

  // Limit of zero and one; upper data bits must be dropped
  task automatic test_iteration_limits();
    program_window(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0000);
    send_pixel(12'd1, 12'd2);
    send_pixel(12'd4095, 0);
    wait_idle();
    write_reg(mbe_pkg::REG_MAX_ITER, 32'hFFFE_0001);
    send_pixel(0, 12'd4095);
    send_pixel(12'd2048, 12'd1365);
    wait_idle();
  endtask

  // Extreme origins and steps; saturated c makes z stick and escape at once
  task automatic test_register_extremes();
    program_window(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd20);
    send_pixel(0, 0);
    send_pixel(12'd1, 0);
    send_pixel(12'd4095, 12'd4095);
    wait_idle();
    program_window(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'd20);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd2730, 12'd1365);
    wait_idle();
  endtask

  // Full 17-bit limit: c = 0 stays inside, a saturated c escapes
  task automatic test_full_limit();
    program_window(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_pixel(0, 12'd4095);
    send_pixel(12'd4095, 12'd4095);
    wait_idle();
  endtask

  // Random windows around the set, with some fully random settings
  task automatic program_random_window();
    logic [31:0] r_origin;
    logic [31:0] i_origin;
    logic [31:0] r_step;
    logic [31:0] i_step;
    int unsigned limit;
    if ($urandom_range(0, 3) == 0) begin
      r_origin = $urandom;
      i_origin = $urandom;
      r_step = $urandom;
      i_step = $urandom;
    end else begin
      r_origin = 32'(-671088640) + $urandom_range(0, 805306368);
      i_origin = 32'(-402653184) + $urandom_range(0, 805306368);
      r_step = {1'($urandom), 31'($urandom_range(0, 262144))};
      i_step = {1'($urandom), 31'($urandom_range(0, 262144))};
    end
    limit = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 48) : $urandom_range(49, 300);
    program_window(r_origin, i_origin, r_step, i_step, {15'($urandom), 17'(limit)});
  endtask

  task automatic test_random_windows(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 8 == 0) begin
        if (i != 0) wait_idle();
        program_random_window();
      end
      send_pixel(COORD_W'($urandom), COORD_W'($urandom));
    end
    wait_idle();
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare each accepted word against the oldest pending pixel
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (pending_pixels.size() == 0) begin
        report_mismatch("word with no pixel pending, out_x", out_x_o, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
        if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
        if (iteration_count_o !== want.count) begin
          report_mismatch("iteration_count", iteration_count_o, want.count);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pixels pending", cycle_count,
               pending_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idle(26, 54);
    test_reset_defaults();
    test_iteration_limits();
    test_register_extremes();
    test_full_limit();
    test_random_windows(34);
    set_idle(54, 26);
    test_random_windows(33);
    set_idle(0, 0);
    test_random_windows(33);

    $display("Sent %0d pixels over %0d register windows, checked %0d result words",
             pixels_sent, windows_programmed, words_checked);
    $display("Limits from zero to the 17-bit maximum, saturated and random windows");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mbe_pkg.sv
src/mbe_mul.sv
src/mbe_regs.sv
src/mandelbrot_escape_time.sv
tb/sv/tb_mandelbrot_escape_time.sv
